FILE: hw/rtl/boxblur_pkg.sv
// boxblur_pkg: shared types, sizes and arithmetic helpers of the 3x3 box blur
// depends on nothing; imported by boxblur_ctrl, boxblur_window, boxblur_div and the top level

package boxblur_pkg;

  // image size limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // fixed field widths
  localparam int unsigned CH_W      = 8;
  localparam int unsigned PIX_W     = 3 * CH_W;
  localparam int unsigned ROW_BUF_W = 2 * PIX_W;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // counter widths follow from the limits
  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned OROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned CMP_W  = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;

  // neighborhood sum: nine 8-bit values; divisor up to nine
  localparam int unsigned SUM_W = 12;
  localparam int unsigned CNT_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

  // reciprocals for exact floor division of values below 2^SUM_W
  localparam logic [13:0] RECIP3       = 14'd5462;
  localparam int unsigned RECIP3_SHIFT = 14;
  localparam logic [13:0] RECIP9       = 14'd3641;
  localparam int unsigned RECIP9_SHIFT = 15;

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            last;
  } pix_out_t;

  // one accepted item on its way to the window stage
  typedef struct packed {
    logic [PIX_W-1:0] pix;   // {blue, green, red}
    logic [COL_W-1:0] addr;
    logic             emit;
    logic             up_ok;
    logic             dn_ok;
    logic             l_ok;
    logic             r_ok;
    logic             last;
  } item_t;

  // row buffer read request
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } rd_req_t;

  // per-channel sums of one output pixel, index 0 is red
  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [CNT_W-1:0]      count;
    logic                  last;
  } sums_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > maxv) r = DIM_W'(maxv);
    return r;
  endfunction

  // round-half-up mean: floor((2*sum + cnt) / (2*cnt)) = floor((sum + cnt/2) / cnt)
  function automatic logic [CH_W-1:0] mean_round(input logic [SUM_W-1:0] sum,
                                                input logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0]    y;
    logic [SUM_W+14:0]   prod;
    logic [SUM_W-1:0]    q;
    y    = sum + SUM_W'(cnt >> 1);
    prod = '0;
    q    = y;
    case (cnt)
      4'd1: q = y;
      4'd2: q = y >> 1;
      4'd3: begin
        prod = y * RECIP3;
        q    = prod[RECIP3_SHIFT +: SUM_W];
      end
      4'd4: q = y >> 2;
      4'd6: begin
        prod = (y >> 1) * RECIP3;
        q    = prod[RECIP3_SHIFT +: SUM_W];
      end
      4'd9: begin
        prod = y * RECIP9;
        q    = prod[RECIP9_SHIFT +: SUM_W];
      end
      default: q = y;
    endcase
    return q[CH_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/boxblur_ram.sv
// boxblur_ram: generic single-clock ram, one write and one registered read port
// depends on nothing

module boxblur_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/boxblur_ctrl.sv
// boxblur_ctrl: config registers, stream position counters and input beat acceptance
// depends on boxblur_pkg

module boxblur_ctrl import boxblur_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_in_t              in_data_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output logic                 item_valid_o,
  output item_t                item_o,
  input  logic                 item_ready_i,
  output rd_req_t              rd_o
);

  logic [DIM_W-1:0]  width_q, height_q;
  logic [COL_W-1:0]  col_q, ocol_q;
  logic [ROW_W-1:0]  row_q;
  logic [OROW_W-1:0] orow_q;
  logic              item_valid_q;
  item_t             item_q, item_d;

  logic [DIM_W-1:0] w_m1, h_m1;
  logic can_load, accept, pixel_phase, ignore, take, emit;
  logic col_end, ocol_end, orow_end, last, cfg_known;

  always_comb begin
    w_m1        = width_q - DIM_W'(1);
    h_m1        = height_q - DIM_W'(1);
    can_load    = !item_valid_q || item_ready_i;
    accept      = in_valid_i && can_load;
    pixel_phase = CMP_W'(row_q) < CMP_W'(height_q);
    // a drain before the frame's pixels are in is dropped
    ignore      = pixel_phase && in_data_i.kind;
    take        = accept && !ignore;
    emit        = (row_q != '0) && !((row_q == ROW_W'(1)) && (col_q == '0));
    col_end     = CMP_W'(col_q) == CMP_W'(w_m1);
    ocol_end    = CMP_W'(ocol_q) == CMP_W'(w_m1);
    orow_end    = CMP_W'(orow_q) == CMP_W'(h_m1);
    last        = orow_end && ocol_end;
    cfg_known   = cfg_valid_i && ((cfg_index_i == REG_WIDTH) || (cfg_index_i == REG_HEIGHT));

    item_d.pix   = pixel_phase ? {in_data_i.blue, in_data_i.green, in_data_i.red} : '0;
    item_d.addr  = col_q;
    item_d.emit  = emit;
    item_d.up_ok = orow_q != '0;
    item_d.dn_ok = (CMP_W'(orow_q) + CMP_W'(1)) < CMP_W'(height_q);
    item_d.l_ok  = ocol_q != '0;
    item_d.r_ok  = (CMP_W'(ocol_q) + CMP_W'(1)) < CMP_W'(width_q);
    item_d.last  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= RESET_WIDTH;
      height_q     <= RESET_HEIGHT;
      col_q        <= '0;
      row_q        <= '0;
      ocol_q       <= '0;
      orow_q       <= '0;
      item_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_WIDTH:  width_q  <= sat_dim(cfg_data_i, MAX_WIDTH);
          REG_HEIGHT: height_q <= sat_dim(cfg_data_i, MAX_HEIGHT);
          default: ;
        endcase
      end
      if (cfg_known || (take && emit && last)) begin
        // new frame
        col_q  <= '0;
        row_q  <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else if (take) begin
        if (col_end) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
        if (emit) begin
          if (ocol_end) begin
            ocol_q <= '0;
            orow_q <= orow_q + OROW_W'(1);
          end else begin
            ocol_q <= ocol_q + COL_W'(1);
          end
        end
      end
      if (take) begin
        item_valid_q <= 1'b1;
      end else if (item_ready_i) begin
        item_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign in_stall_o   = !can_load;
  assign cfg_ready_o  = 1'b1;
  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;
  assign rd_o.en      = take;
  assign rd_o.addr    = col_q;

endmodule

FILE: hw/rtl/boxblur_window.sv
// boxblur_window: two-row line buffer in ram, 3x3 window and neighborhood sums
// depends on boxblur_pkg and boxblur_ram

module boxblur_window import boxblur_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rd_req_t rd_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_ready_o,
  output logic    sum_valid_o,
  output sums_t   sums_o,
  input  logic    sum_ready_i
);

  logic [ROW_BUF_W-1:0] rdata, rs, wr_data, fwd_data_q;
  logic                 fwd_q, wr_en;
  logic [PIX_W-1:0]     win1_q [3];
  logic [PIX_W-1:0]     win2_q [3];
  logic [PIX_W-1:0]     col_new [3];
  logic [2:0]           row_ok, col_ok;
  logic [1:0]           rows, cols;
  logic [SUM_W-1:0]     acc [3];
  logic                 sum_valid_q;
  sums_t                sums_q, sums_d;

  boxblur_ram #(
    .Width(ROW_BUF_W),
    .Depth(MAX_WIDTH)
  ) u_row_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (item_i.addr),
    .wdata_i (wr_data),
    .re_i    (rd_i.en),
    .raddr_i (rd_i.addr),
    .rdata_o (rdata)
  );

  always_comb begin
    item_ready_o = !item_i.emit || !sum_valid_q || sum_ready_i;
    wr_en        = item_valid_i && item_ready_o;
    // bypass when the read met a write to the same column
    rs           = fwd_q ? fwd_data_q : rdata;
    col_new[0]   = rs[PIX_W-1:0];
    col_new[1]   = rs[ROW_BUF_W-1:PIX_W];
    col_new[2]   = item_i.pix;
    wr_data      = {item_i.pix, col_new[1]};

    row_ok = {item_i.dn_ok, 1'b1, item_i.up_ok};
    col_ok = {item_i.r_ok, 1'b1, item_i.l_ok};
    rows   = 2'd1 + {1'b0, item_i.up_ok} + {1'b0, item_i.dn_ok};
    cols   = 2'd1 + {1'b0, item_i.l_ok} + {1'b0, item_i.r_ok};

    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        if (row_ok[r] && col_ok[0]) acc[ch] = acc[ch] + SUM_W'(win1_q[r][CH_W*ch +: CH_W]);
        if (row_ok[r])              acc[ch] = acc[ch] + SUM_W'(win2_q[r][CH_W*ch +: CH_W]);
        if (row_ok[r] && col_ok[2]) acc[ch] = acc[ch] + SUM_W'(col_new[r][CH_W*ch +: CH_W]);
      end
      sums_d.sum[ch] = acc[ch];
    end
    sums_d.count = CNT_W'(rows) * CNT_W'(cols);
    sums_d.last  = item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q       <= 1'b0;
      sum_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win1_q[r] <= '0;
        win2_q[r] <= '0;
      end
    end else begin
      if (rd_i.en) begin
        fwd_q <= wr_en && (rd_i.addr == item_i.addr);
      end
      if (wr_en) begin
        for (int r = 0; r < 3; r++) begin
          win1_q[r] <= win2_q[r];
          win2_q[r] <= col_new[r];
        end
      end
      if (wr_en && item_i.emit) begin
        sum_valid_q <= 1'b1;
      end else if (sum_ready_i) begin
        sum_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      fwd_data_q <= wr_data;
    end
    if (wr_en && item_i.emit) begin
      sums_q <= sums_d;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sums_o      = sums_q;

endmodule

FILE: hw/rtl/boxblur_div.sv
// boxblur_div: rounded division of the neighborhood sums and output register
// depends on boxblur_pkg

module boxblur_div import boxblur_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     sum_valid_i,
  input  sums_t    sums_i,
  output logic     sum_ready_o,
  output logic     out_valid_o,
  output pix_out_t out_data_o,
  input  logic     out_stall_i
);

  logic     out_valid_q, out_go;
  pix_out_t out_q, out_d;

  always_comb begin
    out_go              = !out_valid_q || !out_stall_i;
    out_d.out_red       = mean_round(sums_i.sum[0], sums_i.count);
    out_d.out_green     = mean_round(sums_i.sum[1], sums_i.count);
    out_d.out_blue      = mean_round(sums_i.sum[2], sums_i.count);
    out_d.last          = sums_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_go) begin
      out_valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_go && sum_valid_i) begin
      out_q <= out_d;
    end
  end

  assign sum_ready_o = out_go;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb: streaming 3x3 edge-normalized rgb box blur, top level
// depends on boxblur_pkg, boxblur_ctrl, boxblur_window, boxblur_div, boxblur_ram

// Streaming 3x3 box blur over rgb pixels in raster order. Each output pixel is the
// per-channel mean of the neighbors that lie inside the image (1, 2, 3, 4, 6 or 9
// of them), rounded half up. Unless the output stalls, the block takes one beat
// per clock: every taken beat costs one read and one write of the two-row line
// buffer ram, which has a read and a write port, so the ram sets the rate at one
// pixel per cycle. An output pixel is due image_width+1 input beats after its own
// pixel went in; taking that later beat registers it and reads the ram, the window
// stage registers the sums, and the divider fills the output register. After the
// last pixel of a frame, send image_width+1 drain beats (kind = 1) to flush the
// bottom row; a drain that comes before the frame's pixels are complete is taken
// and dropped, and a pixel that comes after them counts as a drain. Width and
// height are saturated to 1..1024; any write to them restarts the frame. They must
// be written only while the block is idle; the block does not enforce it. The line
// buffer needs no clearing after reset: rows outside the image never reach a sum.

module box_blur_3x3_rgb import boxblur_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_in_t              in_data_i,
  // blurred output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pix_out_t             out_data_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  // accepted beat waiting for its line buffer data
  logic    item_valid, item_ready;
  item_t   item;
  rd_req_t rd_req;

  // sums waiting for the divider
  logic    sum_valid, sum_ready;
  sums_t   sums;

  // counters, registers and the line buffer read address
  boxblur_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready),
    .rd_o         (rd_req)
  );

  // line buffer read-modify-write, window shift and masked sums
  boxblur_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_i         (rd_req),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .sum_valid_o  (sum_valid),
    .sums_o       (sums),
    .sum_ready_i  (sum_ready)
  );

  // divide by neighbor count, hold the result for the consumer
  boxblur_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sums_i      (sums),
    .sum_ready_o (sum_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

`ifndef NO_ASSERTIONS
  // a beat that reads the line buffer occupies the window stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_req.en |=> item_valid)
    else $error("read issued without an item in the window stage");

  // input only stalls behind an occupied window stage
  assert property (@(posedge clk_i) disable iff (!rst_ni) !item_valid |-> !in_stall_o)
    else $error("input stalled with an empty window stage");

  // sums handed to the divider show up as an output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid && sum_ready) |=> out_valid_o)
    else $error("sums taken but no output beat");
`endif

endmodule
